[design/cartesian_tree_builder_unit_defines.svh]
// Assertion macros for the cartesian tree builder.
// Used by the top level only; synthesis sees empty macro bodies.
`ifndef CARTESIAN_TREE_BUILDER_UNIT_DEFINES_SVH
`define CARTESIAN_TREE_BUILDER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CTB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define CTB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CTB_ASSERT(label, prop, msg)
`define CTB_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[design/ctb_pkg.sv]
// Shared widths for the cartesian tree builder.
// No dependencies.
package ctb_pkg;
    localparam int KEY_W = 32;  // signed key width
    localparam int NUM_W = 10;  // node number width on the result word
endpackage

[design/cartesian_tree_builder_unit.sv]
// Cartesian tree builder (min-rooted) over a monotonic stack held in one RAM.
// Compare state: tests the stack from the top, popping each entry whose key is
// strictly greater, until an entry stays or the stack empties; an overflowing word
// or a push onto an empty stack skips it. One word in flight: the next waits until
// the push state issues the result, held there while stalled. Reset (sync,
// active low) clears stack depth, node counter and handshake state; RAM not cleared.
`include "cartesian_tree_builder_unit_defines.svh"

module cartesian_tree_builder_unit #(
    parameter int NODES = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [ctb_pkg::KEY_W-1:0]  i_key_value,
    input  logic                              i_last_item,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ctb_pkg::NUM_W-1:0]         o_node_number,
    output logic [ctb_pkg::NUM_W-1:0]         o_left_child,
    output logic [ctb_pkg::NUM_W-1:0]         o_parent_node,
    output logic [ctb_pkg::NUM_W-1:0]         o_root_node,
    output logic                              o_overflow
);
    import ctb_pkg::*;

    localparam int DW = $clog2(NODES + 1);  // counter / depth width
    localparam int AW = $clog2(NODES);      // RAM address width
    localparam int EW = KEY_W + DW;         // RAM entry: {key, node}

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_PUSH
    } t_state;

    t_state                  r_state;
    logic [DW-1:0]           r_depth;
    logic [DW-1:0]           r_count;
    logic [DW-1:0]           r_root;
    logic [DW-1:0]           r_j;
    logic [DW-1:0]           r_node;
    logic [DW-1:0]           r_left;
    logic [DW-1:0]           r_parent;
    logic signed [KEY_W-1:0] r_key;
    logic                    r_last;
    logic                    r_ovf;
    logic                    r_out_valid;

    logic [EW-1:0]           r_mem [NODES];
    logic [EW-1:0]           r_rd;
    logic [AW-1:0]           rd_addr;
    logic signed [KEY_W-1:0] rd_key;
    logic [DW-1:0]           rd_node;
    logic [DW-1:0]           n_j;
    logic                    in_acc;
    logic                    out_free;
    logic                    full;
    logic                    wr_en;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign full     = (r_count == DW'(NODES));
    assign n_j      = r_j - DW'(1);
    assign rd_key   = $signed(r_rd[EW-1:DW]);
    assign rd_node  = r_rd[DW-1:0];
    assign wr_en    = (r_state == S_PUSH) && out_free && !r_ovf;

    // Idle: fetch the stack top. Compare: prefetch the entry below the one
    // under test, used only if this one pops.
    always_comb begin
        if (r_state == S_IDLE) begin
            rd_addr = AW'(r_depth - DW'(1));
        end else begin
            rd_addr = AW'(n_j - DW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[r_j[AW-1:0]] <= {r_key, r_node};
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_PUSH && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_key    <= i_key_value;
                        r_last   <= i_last_item;
                        r_ovf    <= full;
                        r_node   <= r_count + DW'(1);
                        r_left   <= '0;
                        r_parent <= '0;
                        r_j      <= r_depth;
                        if (!full) begin
                            r_count <= r_count + DW'(1);
                        end
                        if (full || r_depth == '0) begin
                            r_state <= S_PUSH;
                        end else begin
                            r_state <= S_CMP;
                        end
                    end
                end
                S_CMP: begin
                    // only strictly greater keys pop
                    if (rd_key > r_key) begin
                        r_left <= rd_node;
                        r_j    <= n_j;
                        if (n_j == '0) begin
                            r_state <= S_PUSH;
                        end
                    end else begin
                        r_parent <= rd_node;
                        r_state  <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        o_left_child  <= NUM_W'(r_left);
                        o_parent_node <= NUM_W'(r_parent);
                        o_overflow    <= r_ovf;
                        if (r_ovf) begin
                            o_node_number <= '0;
                            o_root_node   <= (r_depth != '0) ? NUM_W'(r_root) : '0;
                        end else begin
                            o_node_number <= NUM_W'(r_node);
                            o_root_node   <= (r_j == '0) ? NUM_W'(r_node) : NUM_W'(r_root);
                            if (r_j == '0) begin
                                r_root <= r_node;
                            end
                        end
                        if (r_last) begin
                            r_depth <= '0;
                            r_count <= '0;
                        end else if (!r_ovf) begin
                            r_depth <= r_j + DW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `CTB_ASSERT(a_depth_le_count, r_depth <= r_count, "stack deeper than node count")
    `CTB_ASSERT(a_count_bound, r_count <= DW'(NODES), "node counter past store size")
    `CTB_ASSERT(a_ovf_no_node, o_valid && o_overflow |-> o_node_number == '0, "numbered drop")
    `CTB_ASSERT(a_busy_after_accept, in_acc |=> o_stall, "input taken while a word is in flight")
endmodule

[tb/cartesian_tree_builder_unit_tb.sv]
// Testbench for cartesian_tree_builder_unit: a local predictor and a result check.
// Drives directed, full-store and random key streams. Depends on ctb_pkg and the DUT.
`timescale 1ns / 100ps

module cartesian_tree_builder_unit_tb;
    import ctb_pkg::*;

    localparam int NODES      = 512;
    localparam int IDLE_PCT   = 23;
    localparam int HANG_LIMIT = 4000;
    localparam int RAND_WORDS = 800;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct packed {
        logic [NUM_W-1:0] node_number;
        logic [NUM_W-1:0] left_child;
        logic [NUM_W-1:0] parent_node;
        logic [NUM_W-1:0] root_node;
        logic             overflow;
    } t_tree_link;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    logic signed [KEY_W-1:0] i_key_value = '0;
    logic                    i_last_item = 1'b0;
    logic                    i_stall     = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic [NUM_W-1:0]        o_node_number;
    logic [NUM_W-1:0]        o_left_child;
    logic [NUM_W-1:0]        o_parent_node;
    logic [NUM_W-1:0]        o_root_node;
    logic                    o_overflow;

    // predictor state: monotonic stack of (node, key)
    logic signed [KEY_W-1:0] stk_key [NODES];
    logic [NUM_W-1:0]        stk_node[NODES];
    int                      stk_depth  = 0;
    int                      node_count = 0;

    t_tree_link pending_links[$];
    int         err_cnt      = 0;
    int         quiet_cycles = 0;
    bit         idle_en      = 1'b1;

    cartesian_tree_builder_unit #(
        .NODES(NODES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_key_value  (i_key_value),
        .i_last_item  (i_last_item),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_node_number(o_node_number),
        .o_left_child (o_left_child),
        .o_parent_node(o_parent_node),
        .o_root_node  (o_root_node),
        .o_overflow   (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    function automatic void predict_links(input logic signed [KEY_W-1:0] key,
                                          input logic last);
        t_tree_link want;
        int         j;
        want = '0;
        if (node_count >= NODES) begin
            want.overflow = 1'b1;
        end else begin
            node_count++;
            want.node_number = node_count[NUM_W-1:0];
            j = stk_depth;
            while (j > 0 && stk_key[j-1] > key) j--;
            if (j < stk_depth) want.left_child = stk_node[j];
            if (j > 0) want.parent_node = stk_node[j-1];
            stk_node[j] = want.node_number;
            stk_key[j]  = key;
            stk_depth   = j + 1;
        end
        want.root_node = (stk_depth > 0) ? stk_node[0] : '0;
        if (last) begin
            stk_depth  = 0;
            node_count = 0;
        end
        pending_links.push_back(want);
    endfunction

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_key(input logic signed [KEY_W-1:0] key, input logic last);
        while (idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_key_value <= key;
        i_last_item <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_links(key, last);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(negedge i_clk) i_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);

    always @(posedge i_clk) begin
        t_tree_link want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_links.size() == 0) begin
                $error("result word with nothing expected");
                err_cnt++;
            end else begin
                want = pending_links.pop_front();
                check_field("node_number", want.node_number, o_node_number);
                check_field("left_child", want.left_child, o_left_child);
                check_field("parent_node", want.parent_node, o_parent_node);
                check_field("root_node", want.root_node, o_root_node);
                check_field("overflow", want.overflow, o_overflow);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // extremes, pops, equal keys, lone node, descending chain
    task automatic test_directed_shapes();
        send_key(KEY_MAX, 1'b1);
        send_key(32'sd10, 1'b0);
        send_key(32'sd20, 1'b0);
        send_key(32'sd30, 1'b0);
        send_key(32'sd15, 1'b0);
        send_key(32'sd15, 1'b0);
        send_key(32'sd40, 1'b0);
        send_key(-32'sd5, 1'b0);
        send_key(KEY_MIN, 1'b0);
        send_key(KEY_MIN, 1'b0);
        send_key(KEY_MAX, 1'b0);
        send_key(-32'sd1, 1'b0);
        send_key(32'sd0, 1'b1);
        send_key(32'sd3, 1'b0);
        send_key(32'sd2, 1'b0);
        send_key(32'sd1, 1'b1);
    endtask

    // 511 rising keys, one minimum key popping them all, three dropped words, a lone node
    task automatic test_store_full();
        logic signed [KEY_W-1:0] k;
        for (int i = 0; i < NODES - 1; i++) begin
            k = 32'hC000_0000 + i * 32'h0010_0000 + $urandom_range(0, 32'h000F_FFFF);
            send_key(k, 1'b0);
        end
        send_key(KEY_MIN, 1'b0);
        send_key($urandom, 1'b0);
        send_key($urandom, 1'b0);
        send_key($urandom, 1'b1);
        send_key($urandom, 1'b1);
    endtask

    // equal keys never pop, so the stack fills to its full depth
    task automatic test_equal_keys_full();
        logic signed [KEY_W-1:0] k;
        k = $urandom;
        idle_en = 1'b0;
        for (int i = 0; i < NODES; i++) send_key(k, i == NODES - 1);
        idle_en = 1'b1;
    endtask

    task automatic test_random_forests();
        int                      sent;
        int                      len;
        int                      mode;
        logic signed [KEY_W-1:0] k;
        sent = 0;
        while (sent < RAND_WORDS) begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(41, 150) : $urandom_range(1, 40);
            mode = $urandom_range(3);
            k    = $urandom;
            for (int i = 0; i < len; i++) begin
                case (mode)
                    0: k = $urandom;
                    1: k = $signed($urandom_range(8)) - 4;
                    2: k = k + $urandom_range(0, 1000);
                    default: k = k - $urandom_range(0, 1000);
                endcase
                send_key(k, (i == len - 1) || ($urandom_range(49) == 0));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_shapes();
        test_store_full();
        test_equal_keys_full();
        test_random_forests();
        i_valid <= 1'b0;
        while (pending_links.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
